>>> hw/rtl/windowed_level_classifier_servo_defines.svh
// ----------------------------------------------------------------------------
// windowed_level_classifier_servo_defines.svh
// Assertion macros for the windowed level classifier servo block.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_LEVEL_CLASSIFIER_SERVO_DEFINES_SVH
`define WINDOWED_LEVEL_CLASSIFIER_SERVO_DEFINES_SVH

`ifndef SYNTHESIS
// check a property at every rising clock edge outside reset
`define WLC_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check that a condition in one cycle implies a consequence in the next
`define WLC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WLC_ASSERT(name, clk, rst_n, prop, msg)
`define WLC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> hw/rtl/wlc_pkg.sv
// ----------------------------------------------------------------------------
// wlc_pkg
// Types, register indexes, class codes and constants of the level classifier.
// ----------------------------------------------------------------------------
package wlc_pkg;

    localparam int SAMPLE_W = 10;
    localparam int CLASS_W  = 3;
    localparam int PULSE_W  = 13;
    localparam int COLOUR_W = 24;
    localparam int CFG_W    = 32;
    localparam int REG_IDX_W = 3;
    localparam int WINDOWS  = 4;
    localparam int ANGLE_W  = 8;
    localparam int COUNT_W  = 4;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [CLASS_W-1:0]  class_t;
    typedef logic [PULSE_W-1:0]  pulse_t;
    typedef logic [COLOUR_W-1:0] colour_t;
    typedef logic [ANGLE_W-1:0]  angle_t;
    typedef logic [COUNT_W-1:0]  count_t;

    typedef struct packed {
        sample_t hi;
        sample_t lo;
    } window_t;

    typedef struct packed {
        sample_t average;
        class_t  cls;
    } class_result_t;

    localparam logic [REG_IDX_W-1:0] REG_WINDOW_ONE    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_TWO    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_THREE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_FOUR   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ANGLE_TABLE   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CONFIRM_COUNT = 3'd5;

    localparam class_t CLASS_NONE  = 3'd0;
    localparam class_t CLASS_ONE   = 3'd1;
    localparam class_t CLASS_TWO   = 3'd2;
    localparam class_t CLASS_THREE = 3'd3;
    localparam class_t CLASS_FOUR  = 3'd4;

    localparam window_t WINDOW_ONE_RST   = window_t'(20'd553460);
    localparam window_t WINDOW_TWO_RST   = window_t'(20'd604720);
    localparam window_t WINDOW_THREE_RST = window_t'(20'd645720);
    localparam window_t WINDOW_FOUR_RST  = window_t'(20'd696960);
    localparam logic [CFG_W-1:0] ANGLE_TABLE_RST = 32'd3027778560;
    localparam count_t CONFIRM_COUNT_RST = 4'd3;

    localparam pulse_t  PULSE_MIN = 13'd1000;
    localparam pulse_t  PULSE_MAX = 13'd5000;
    localparam angle_t  ANGLE_MAX = 8'd180;
    // 200 * ceil(2^19 / 9): 4000*a/180 == (a * PULSE_RECIP) >> 19 for a <= 180
    localparam logic [31:0] PULSE_RECIP = 32'd11651000;
    localparam int PULSE_SHIFT = 19;

    localparam colour_t COLOUR_OFF   = 24'h000000;
    localparam colour_t COLOUR_ONE   = 24'hFF0050;
    localparam colour_t COLOUR_TWO   = 24'hFF0000;
    localparam colour_t COLOUR_THREE = 24'hFFFF00;
    localparam colour_t COLOUR_FOUR  = 24'h00FF00;

    function automatic pulse_t pulse_of_angle(input angle_t angle);
        angle_t      clamped;
        logic [31:0] prod;
        clamped = (angle > ANGLE_MAX) ? ANGLE_MAX : angle;
        prod    = 32'(clamped) * PULSE_RECIP;
        return PULSE_MIN + PULSE_W'(prod[30:PULSE_SHIFT]);
    endfunction

    function automatic colour_t colour_of_class(input class_t cls);
        colour_t colour;
        unique case (cls)
            CLASS_ONE:   colour = COLOUR_ONE;
            CLASS_TWO:   colour = COLOUR_TWO;
            CLASS_THREE: colour = COLOUR_THREE;
            CLASS_FOUR:  colour = COLOUR_FOUR;
            default:     colour = COLOUR_OFF;
        endcase
        return colour;
    endfunction

endpackage

>>> hw/rtl/wlc_if.sv
// ----------------------------------------------------------------------------
// wlc_if
// Valid/ready channels for sample items and result items.
// ----------------------------------------------------------------------------
interface wlc_sample_if;
    import wlc_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface wlc_result_if;
    import wlc_pkg::*;

    logic    valid;
    logic    ready;
    sample_t average;
    class_t  detected_class;
    class_t  confirmed_class;
    logic    changed;
    pulse_t  servo_pulse;
    colour_t led_colour;

    modport source (
        output valid, output average, output detected_class, output confirmed_class,
        output changed, output servo_pulse, output led_colour, input ready
    );
    modport sink (
        input valid, input average, input detected_class, input confirmed_class,
        input changed, input servo_pulse, input led_colour, output ready
    );
endinterface

>>> hw/rtl/windowed_level_classifier_servo.sv
// ----------------------------------------------------------------------------
// windowed_level_classifier_servo
// Block averaging of sensor samples, level window classification with
// confirmation, servo pulse and LED fill colour update.
//
//   channel   | dir | handshake       | payload
//   ----------+-----+-----------------+-----------------------------------
//   samples   | in  | valid / ready   | sample
//   results   | out | valid / ready   | average, detected_class,
//             |     |                 | confirmed_class, changed,
//             |     |                 | servo_pulse, led_colour
//   wr_*      | in  | wr_en           | wr_index, wr_data
//
// One sample item per cycle while the sample input is not stalled. The
// sum of each block of AVG_COUNT samples goes into the block register;
// the combinational reciprocal multiply and window compare then feed the
// result register. A stalled result holds one finished block; a second
// block stalls the sample input. Reset restores registers and state at once.
// ----------------------------------------------------------------------------
`include "windowed_level_classifier_servo_defines.svh"

module windowed_level_classifier_servo #(
    parameter int AVG_COUNT = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    wlc_sample_if.sink                    samples,
    wlc_result_if.source                  results,
    input  logic                          wr_en,
    input  logic [wlc_pkg::REG_IDX_W-1:0] wr_index,
    input  logic [wlc_pkg::CFG_W-1:0]     wr_data
);
    import wlc_pkg::*;

    localparam int SUM_W = SAMPLE_W + $clog2(AVG_COUNT);
    localparam int IDX_W = (AVG_COUNT > 1) ? $clog2(AVG_COUNT) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(AVG_COUNT - 1);

    window_t [WINDOWS-1:0] window_reg;
    logic [CFG_W-1:0]      angle_reg;
    count_t                confirm_reg;

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             blk_valid_reg, blk_valid_next;
    logic [SUM_W-1:0] blk_sum_reg;

    count_t  stable_reg, stable_next;
    class_t  cur_reg, cur_next;
    pulse_t  pulse_reg, pulse_next;
    colour_t colour_reg, colour_next;
    logic    changed_next;

    logic    res_valid_reg;
    sample_t avg_reg;
    class_t  det_reg;
    logic    changed_reg;

    logic          adv;
    logic          acc;
    logic          last;
    logic          fire;
    class_result_t cr;
    count_t        cnt_inc;
    pulse_t [WINDOWS-1:0] pulse_by_class;
    pulse_t        pulse_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg[0] <= WINDOW_ONE_RST;
            window_reg[1] <= WINDOW_TWO_RST;
            window_reg[2] <= WINDOW_THREE_RST;
            window_reg[3] <= WINDOW_FOUR_RST;
            angle_reg     <= ANGLE_TABLE_RST;
            confirm_reg   <= CONFIRM_COUNT_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_WINDOW_ONE:    window_reg[0] <= window_t'(wr_data[19:0]);
                REG_WINDOW_TWO:    window_reg[1] <= window_t'(wr_data[19:0]);
                REG_WINDOW_THREE:  window_reg[2] <= window_t'(wr_data[19:0]);
                REG_WINDOW_FOUR:   window_reg[3] <= window_t'(wr_data[19:0]);
                REG_ANGLE_TABLE:   angle_reg     <= wr_data;
                REG_CONFIRM_COUNT: confirm_reg   <= wr_data[COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    assign adv           = !res_valid_reg || results.ready;
    assign samples.ready = !blk_valid_reg || adv;
    assign acc           = samples.valid && samples.ready;
    assign last          = (idx_reg == IDX_LAST);
    assign fire          = blk_valid_reg && adv;

    always_comb
    begin
        sum_next       = sum_reg;
        idx_next       = idx_reg;
        blk_valid_next = blk_valid_reg;
        if (adv)
            blk_valid_next = 1'b0;
        if (acc)
        begin
            if (last)
            begin
                sum_next       = '0;
                idx_next       = '0;
                blk_valid_next = 1'b1;
            end
            else
            begin
                sum_next = sum_reg + SUM_W'(samples.sample);
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            idx_reg       <= '0;
            blk_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            idx_reg       <= idx_next;
            blk_valid_reg <= blk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && last)
            blk_sum_reg <= sum_reg + SUM_W'(samples.sample);
    end

    wlc_classify #(
        .AVG_COUNT (AVG_COUNT)
    ) u_classify (
        .sum     (blk_sum_reg),
        .windows (window_reg),
        .result  (cr)
    );

    always_comb
    begin
        for (int k = 0; k < WINDOWS; k++)
        begin
            pulse_by_class[k] = pulse_of_angle(angle_reg[ANGLE_W*k +: ANGLE_W]);
        end
    end

    always_comb
    begin
        unique case (cr.cls)
            CLASS_ONE:   pulse_sel = pulse_by_class[0];
            CLASS_TWO:   pulse_sel = pulse_by_class[1];
            CLASS_THREE: pulse_sel = pulse_by_class[2];
            default:     pulse_sel = pulse_by_class[3];
        endcase
    end

    assign cnt_inc = stable_reg + 1'b1;

    always_comb
    begin
        stable_next  = stable_reg;
        cur_next     = cur_reg;
        pulse_next   = pulse_reg;
        colour_next  = colour_reg;
        changed_next = 1'b0;
        if (fire)
        begin
            if ((cr.cls == cur_reg) || (cr.cls == CLASS_NONE))
                stable_next = '0;
            else if (cnt_inc >= confirm_reg)
            begin
                stable_next  = '0;
                cur_next     = cr.cls;
                pulse_next   = pulse_sel;
                colour_next  = colour_of_class(cr.cls);
                changed_next = 1'b1;
            end
            else
                stable_next = cnt_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg    <= '0;
            cur_reg       <= CLASS_NONE;
            pulse_reg     <= PULSE_MIN;
            colour_reg    <= COLOUR_OFF;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            stable_reg <= stable_next;
            cur_reg    <= cur_next;
            pulse_reg  <= pulse_next;
            colour_reg <= colour_next;
            if (adv)
                res_valid_reg <= blk_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            avg_reg     <= cr.average;
            det_reg     <= cr.cls;
            changed_reg <= changed_next;
        end
    end

    assign results.valid           = res_valid_reg;
    assign results.average         = avg_reg;
    assign results.detected_class  = det_reg;
    assign results.confirmed_class = cur_reg;
    assign results.changed         = changed_reg;
    assign results.servo_pulse     = pulse_reg;
    assign results.led_colour      = colour_reg;

    `WLC_ASSERT(a_idx_range, clk, rst_n, idx_reg <= IDX_LAST, "sample index beyond block")
    `WLC_ASSERT(a_changed_class, clk, rst_n, results.valid && results.changed |-> results.confirmed_class != CLASS_NONE && results.detected_class == results.confirmed_class, "confirmation without matching class")
    `WLC_ASSERT(a_pulse_range, clk, rst_n, results.servo_pulse >= PULSE_MIN && results.servo_pulse <= PULSE_MAX, "servo pulse out of range")
    `WLC_ASSERT_NEXT(a_blk_hold, clk, rst_n, blk_valid_reg && !adv, blk_valid_reg && $stable(blk_sum_reg), "stalled block lost")

endmodule

>>> hw/rtl/wlc_classify.sv
// ----------------------------------------------------------------------------
// wlc_classify
// Block mean by reciprocal multiply and first-match window classification.
// ----------------------------------------------------------------------------
module wlc_classify #(
    parameter int AVG_COUNT = 32,
    localparam int SUM_W = wlc_pkg::SAMPLE_W + $clog2(AVG_COUNT)
) (
    input  logic [SUM_W-1:0]                           sum,
    input  wlc_pkg::window_t [wlc_pkg::WINDOWS-1:0]    windows,
    output wlc_pkg::class_result_t                     result
);
    import wlc_pkg::*;

    // ceil(2^32 / AVG_COUNT) is exact for sums below 2^16
    localparam longint unsigned RECIP = ((64'd1 << 32) + AVG_COUNT - 1) / AVG_COUNT;
    localparam int PROD_W = SUM_W + 33;
    localparam logic [32:0] RECIP_C = 33'(RECIP);

    logic [PROD_W-1:0]  prod;
    sample_t            average;
    logic [WINDOWS-1:0] hit;

    assign prod    = PROD_W'(sum) * PROD_W'(RECIP_C);
    assign average = prod[32 +: SAMPLE_W];

    always_comb
    begin
        for (int k = 0; k < WINDOWS; k++)
        begin
            hit[k] = (average >= windows[k].lo) && (average <= windows[k].hi);
        end
    end

    always_comb
    begin
        result.average = average;
        priority if (hit[0])
            result.cls = CLASS_ONE;
        else if (hit[1])
            result.cls = CLASS_TWO;
        else if (hit[2])
            result.cls = CLASS_THREE;
        else if (hit[3])
            result.cls = CLASS_FOUR;
        else
            result.cls = CLASS_NONE;
    end

endmodule
